>>> hw/rtl/rfvf_pkg.sv
// Package: types and constants for the reservoir frequent-value finder.
package rfvf_pkg;
    localparam int Size = 64;
    localparam int IdxW = $clog2(Size);
    localparam int CntW = $clog2(Size + 1);
    localparam int ValW = 48;
    localparam logic [6:0] MinCountReset = 7'd8;
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [ValW-1:0] sample_value;
        logic [6:0]      random_draw;
    } in_beat_t;

    typedef struct packed {
        logic [ValW-1:0] frequent_value;
        logic [6:0]      occurrences;
        logic            found;
        logic            last;
    } out_beat_t;
endpackage

>>> hw/rtl/reservoir_frequent_value_finder_unit.sv
// Top level: reservoir sampler with frequent-value report.
//
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_ready  | in_beat_t
// out     | out | out_valid/out_ready| out_beat_t
// cfg     | in  | cfg_valid/cfg_ready| min_count (7 bits)
//
// A sample beat makes at most one RAM write.
// A report walks the n filled entries repeatedly: each pass finds the smallest
// value above the one found by the previous pass and counts it, scanning over the
// single RAM read port and then emitting.
// Results wait in an output register; a stalled output holds the pass.
// Reset zeroes the fill count and restores the threshold; RAM contents are not cleared.
module reservoir_frequent_value_finder_unit
    import rfvf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [6:0] cfg_data
);
    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t          state_reg;
    logic [CntW-1:0] fill_reg;
    logic [6:0]      min_reg;
    logic [IdxW:0]   idx_reg;        // read address issued
    logic            rd_v_reg;       // rdata valid this cycle
    logic [ValW-1:0] lo_reg;         // values must exceed this (when have_lo)
    logic            have_lo_reg;
    logic [ValW-1:0] best_reg;
    logic            best_v_reg;
    logic [6:0]      cnt_reg;
    logic            any_reg;
    out_beat_t       held_reg;       // latest qualifying value, sent once the next is known
    logic            out_v_reg;
    out_beat_t       out_reg;
    logic [ValW-1:0] rdata;

    logic samp;
    logic            we;
    logic [IdxW-1:0] waddr;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !out_v_reg;
    assign samp      = in_valid && in_ready && in_data.req_type == REQ_SAMPLE;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = in_data.random_draw[IdxW-1:0];
        if (samp)
        begin
            if (fill_reg < CntW'(Size))
            begin
                we    = 1'b1;
                waddr = fill_reg[IdxW-1:0];
            end
            else if (in_data.random_draw < 7'(Size))
            begin
                we = 1'b1;
            end
        end
    end

    rfvf_ram #(.Depth(Size), .Width(ValW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_data.sample_value),
        .raddr (idx_reg[IdxW-1:0]),
        .rdata (rdata)
    );

    logic cand;
    assign cand = !have_lo_reg || rdata > lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            min_reg     <= MinCountReset;
            idx_reg     <= '0;
            rd_v_reg    <= 1'b0;
            have_lo_reg <= 1'b0;
            best_v_reg  <= 1'b0;
            any_reg     <= 1'b0;
            out_v_reg   <= 1'b0;
            cnt_reg     <= '0;
            lo_reg      <= '0;
            best_reg    <= '0;
            held_reg    <= '0;
            out_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
            if (out_v_reg && out_ready && state_reg != ST_EMIT)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (samp && fill_reg < CntW'(Size))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    if (in_valid && in_ready && in_data.req_type == REQ_REPORT)
                    begin
                        state_reg   <= ST_SCAN;
                        have_lo_reg <= 1'b0;
                        any_reg     <= 1'b0;
                        idx_reg     <= '0;
                        rd_v_reg    <= 1'b0;
                        best_v_reg  <= 1'b0;
                        cnt_reg     <= '0;
                    end
                end
                ST_SCAN:
                begin
                    rd_v_reg <= (idx_reg < (IdxW+1)'(fill_reg));
                    if (idx_reg < (IdxW+1)'(fill_reg))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_v_reg)
                    begin
                        if (cand)
                        begin
                            if (!best_v_reg || rdata < best_reg)
                            begin
                                best_reg   <= rdata;
                                best_v_reg <= 1'b1;
                                cnt_reg    <= 7'd1;
                            end
                            else if (rdata == best_reg)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                    end
                    if (!rd_v_reg && idx_reg >= (IdxW+1)'(fill_reg))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                default:
                begin
                    if (!out_v_reg || out_ready)
                    begin
                        idx_reg    <= '0;
                        rd_v_reg   <= 1'b0;
                        best_v_reg <= 1'b0;
                        cnt_reg    <= '0;
                        if (!best_v_reg)
                        begin
                            state_reg <= ST_IDLE;
                            out_v_reg <= 1'b1;
                            if (!any_reg)
                            begin
                                out_reg <= '{frequent_value: '0, occurrences: '0,
                                             found: 1'b0, last: 1'b1};
                            end
                            else
                            begin
                                out_reg <= '{frequent_value: held_reg.frequent_value,
                                             occurrences: held_reg.occurrences,
                                             found: 1'b1, last: 1'b1};
                            end
                        end
                        else
                        begin
                            state_reg   <= ST_SCAN;
                            lo_reg      <= best_reg;
                            have_lo_reg <= 1'b1;
                            if (cnt_reg > min_reg)
                            begin
                                out_v_reg <= any_reg;
                                if (any_reg)
                                begin
                                    out_reg <= held_reg;
                                end
                                any_reg  <= 1'b1;
                                held_reg <= '{frequent_value: best_reg, occurrences: cnt_reg,
                                              found: 1'b1, last: 1'b0};
                            end
                            else
                            begin
                                out_v_reg <= 1'b0;
                            end
                        end
                    end
                end
            endcase
        end
    end
endmodule

>>> hw/rtl/rfvf_ram.sv
// Single-port-write, single-read synchronous RAM for the reservoir.
module rfvf_ram
    import rfvf_pkg::*;
#(
    parameter int Depth = 64,
    parameter int Width = 48
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
